@@ rtl/top_k_sorted_insert_table_assert.svh @@
// Assertion macros shared by the top-k sorted insert table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TOP_K_SORTED_INSERT_TABLE_ASSERT_SVH
`define TOP_K_SORTED_INSERT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TKST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tkst assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TKST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tkst assertion failed");

// Plain invariant checked at every edge out of reset
`define TKST_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("tkst assertion failed");

`endif

@@ rtl/tkst_pkg.sv @@
// Package for the top-k sorted insert table: item types, entry type, constants.
// No dependencies.
package tkst_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 64;

    // Fixed field widths
    localparam int KEY_W   = 24;
    localparam int LEVEL_W = 8;
    localparam int STAMP_W = 32;
    localparam int NAME_W  = 16;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Input item
    typedef struct packed {
        logic               req_type;
        logic [KEY_W-1:0]   new_key;
        logic [LEVEL_W-1:0] new_level;
        logic [STAMP_W-1:0] new_stamp;
        logic [NAME_W-1:0]  new_name_handle;
        logic [SLOT_W-1:0]  read_index;
    } t_req;

    // Result item
    typedef struct packed {
        logic               inserted;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   entry_key;
        logic [LEVEL_W-1:0] entry_level;
        logic [STAMP_W-1:0] entry_stamp;
        logic [NAME_W-1:0]  entry_name_handle;
        logic [COUNT_W-1:0] filled_count;
    } t_res;

    // One table entry as held by a cell
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
        logic [STAMP_W-1:0] stamp;
        logic [NAME_W-1:0]  name;
    } t_entry;

    // Per-cell controls from the top level
    typedef struct packed {
        logic ins;   // insert item accepted this cycle
        logic sel;   // this cell is addressed by a read
    } t_cell_ctl;

endpackage

@@ rtl/tkst_cell.sv @@
// One slot of the sorted table: holds an entry, compares it against the new key
// and shifts from its upper neighbor on insert. Depends on tkst_pkg.
module tkst_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkst_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_ge,
    input  tkst_pkg::t_entry   i_prev_ent,
    input  tkst_pkg::t_entry   i_new_ent,
    output tkst_pkg::t_entry   o_ent,
    output logic               o_ge,
    output tkst_pkg::t_entry   o_rd
);
    import tkst_pkg::*;

    t_entry r_ent;

    // New key lands here or above when it is not smaller than the held key
    assign o_ge = (i_new_ent.key >= r_ent.key);

    // First cell whose key is at or below the new key takes the new entry, the cells below it shift down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else if (i_ctl.ins && o_ge) begin
            r_ent <= i_prev_ge ? i_prev_ent : i_new_ent;
        end
    end

    assign o_ent = r_ent;

    // Read data gated so the top level can OR all cells together
    assign o_rd = i_ctl.sel ? r_ent : '0;

endmodule

@@ rtl/top_k_sorted_insert_table.sv @@
// Top level of the top-k sorted insert table: row of slot cells, read merge,
// fill counter and result register. Depends on tkst_pkg, tkst_cell and the assert header.
//
//  channel  | handshake            | payload | direction
//  ---------+----------------------+---------+----------
//  request  | start / busy         | i_req   | in
//  result   | o_done (one cycle)   | o_res   | out
//
// One item per cycle: every cell compares and shifts in the accept cycle.
// The result appears on o_res with o_done in the cycle after acceptance.
// Synchronous active-low reset clears all cells; busy is high for one cycle after it.
// Results cannot be stalled; o_done pulses for one cycle per accepted item.
`include "top_k_sorted_insert_table_assert.svh"

module top_k_sorted_insert_table #(
    parameter int ENTRIES = tkst_pkg::ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tkst_pkg::t_req i_req,
    output logic           o_done,
    output tkst_pkg::t_res o_res
);
    import tkst_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic               accept;
    logic               ins;
    t_entry             new_ent;
    t_entry             ent     [ENTRIES];
    t_entry             rd      [ENTRIES];
    t_entry             prev_ent[ENTRIES];
    logic [ENTRIES-1:0] ge;
    logic [ENTRIES-1:0] prev_ge;
    logic [ENTRIES-1:0] first;
    t_entry             rd_or;
    logic [IDX_W-1:0]   slot_idx;
    logic               placed;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_busy;
    logic               r_done;
    t_res               r_res;
    t_res               n_res;

    assign accept = start && !busy;
    assign ins    = accept && (i_req.req_type == REQ_INSERT);

    assign new_ent.key   = i_req.new_key;
    assign new_ent.level = i_req.new_level;
    assign new_ent.stamp = i_req.new_stamp;
    assign new_ent.name  = i_req.new_name_handle;

    // Row of cells, each fed by its upper neighbor
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        t_cell_ctl ctl;

        if (i == 0) begin : g_head
            assign prev_ge[i]  = 1'b0;
            assign prev_ent[i] = '0;
        end else begin : g_body
            assign prev_ge[i]  = ge[i-1];
            assign prev_ent[i] = ent[i-1];
        end

        assign ctl.ins   = ins;
        assign ctl.sel   = (CMP_W'(i_req.read_index) == CMP_W'(i));
        assign first[i]  = ge[i] && !prev_ge[i];

        tkst_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_prev_ge  (prev_ge[i]),
            .i_prev_ent (prev_ent[i]),
            .i_new_ent  (new_ent),
            .o_ent      (ent[i]),
            .o_ge       (ge[i]),
            .o_rd       (rd[i])
        );
    end

    // Merge read data and encode the insert position
    always_comb begin
        rd_or    = '0;
        slot_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rd_or    = rd_or | rd[i];
            slot_idx = slot_idx | (first[i] ? IDX_W'(i) : '0);
        end
    end

    // Table is sorted, so the last cell's compare says whether any slot was found
    assign placed = ge[ENTRIES-1];

    // Nonzero keys sit at the front; a nonzero insert adds one unless the table is full
    always_comb begin
        n_count = r_count;
        if (ins && placed && (i_req.new_key != '0) && (ent[ENTRIES-1].key == '0)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Result fields
    always_comb begin
        n_res              = '0;
        n_res.filled_count = COUNT_W'(n_count);
        if (i_req.req_type == REQ_INSERT) begin
            n_res.inserted = placed;
            n_res.slot     = placed ? SLOT_W'(slot_idx) : '0;
        end else begin
            n_res.entry_key         = rd_or.key;
            n_res.entry_level       = rd_or.level;
            n_res.entry_stamp       = rd_or.stamp;
            n_res.entry_name_handle = rd_or.name;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_done  <= accept;
            r_count <= n_count;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

    // Sorted table gives at most one insert position
    `TKST_ASSERT_ALWAYS(a_first_onehot, i_clk, i_rst_n, $onehot0(first))
    // Every accepted item gives exactly one result in the next cycle
    `TKST_ASSERT_NEXT(a_done_after_accept, i_clk, i_rst_n, accept, o_done)
    `TKST_ASSERT_IMPLY(a_done_has_accept, i_clk, i_rst_n, o_done, $past(accept))
    // Fill counter stays within the table
    `TKST_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(ENTRIES))
    // A missed insert reports slot zero
    `TKST_ASSERT_IMPLY(a_miss_slot_zero, i_clk, i_rst_n, o_done && !o_res.inserted, o_res.slot == '0)

endmodule
